>>> src/sbm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the SPI backup memory slave.
// No dependencies; used by the front queue, the back engine and the top level.
package sbm_pkg;

    localparam int STORE_BYTES_DEFAULT = 65536;
    localparam int ADDR_W = 24;
    localparam int SIZE_W = 17;

    // One request as it travels from the front queue to the back engine
    typedef struct packed {
        logic       release_cs;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic [1:0]        address_bytes;
        logic [SIZE_W-1:0] size_in_use;
        logic              writable;
    } cfg_t;

endpackage

>>> src/spi_backup_memory_slave.sv
`timescale 1ns / 1ps
// SPI backup memory slave is a byte-level model of a 25xx-style serial EEPROM/flash.
// Sustained rate is one request per clock once clearing is done and while results are taken; a
// request waits in the input queue, then the command engine writes the result register, where a
// store read lands directly. After reset the store is cleared one byte per cycle, during which
// s_tready stays low; the APB port works throughout. Configuration must only be written while
// no request is outstanding.
// Top level: APB configuration registers, front queue and back engine. Depends on sbm_pkg,
// sbm_front and sbm_back.
module spi_backup_memory_slave
#(
    parameter int STORE_BYTES = sbm_pkg::STORE_BYTES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_in
    input  logic        s_tlast,    // cmd: 1 = chip select released
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] data_out
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] REG_ADDRESS_BYTES = 2'd0;
    localparam logic [1:0] REG_SIZE_IN_USE   = 2'd1;
    localparam logic [1:0] REG_WRITABLE      = 2'd2;

    sbm_pkg::cfg_t  cfg_reg;
    sbm_pkg::item_t q_item;
    logic           q_valid;
    logic           q_ready;
    logic           clearing;
    logic           cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.address_bytes <= 2'd2;
            cfg_reg.size_in_use   <= 17'h10000;
            cfg_reg.writable      <= 1'b1;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_ADDRESS_BYTES: cfg_reg.address_bytes <= pwdata[1:0];
                REG_SIZE_IN_USE:   cfg_reg.size_in_use   <= pwdata[sbm_pkg::SIZE_W-1:0];
                REG_WRITABLE:      cfg_reg.writable      <= pwdata[0];
                default:           cfg_reg.writable      <= cfg_reg.writable;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_ADDRESS_BYTES: prdata = {30'd0, cfg_reg.address_bytes};
            REG_SIZE_IN_USE:   prdata = {15'd0, cfg_reg.size_in_use};
            REG_WRITABLE:      prdata = {31'd0, cfg_reg.writable};
            default:           prdata = 32'd0;
        endcase
    end

    sbm_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .hold     (clearing),
        .q_item   (q_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready)
    );

    sbm_back
    #(
        .STORE_BYTES (STORE_BYTES)
    )
    u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_item   (q_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> src/sbm_front.sv
`timescale 1ns / 1ps
// Front end: accepts requests from the slave stream into a two-entry queue.
// Depends on sbm_pkg (item_t).
module sbm_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,    // [7:0] data_in
    input  logic            s_tlast,    // cmd: chip select released
    input  logic            hold,
    output sbm_pkg::item_t  q_item,
    output logic            q_valid,
    input  logic            q_ready
);

    sbm_pkg::item_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           push;
    logic           pop;

    assign s_tready = (count_reg != 2'd2) && !hold;
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg].release_cs <= s_tlast;
            entry_reg[wr_ptr_reg].data       <= s_tdata;
        end
    end

endmodule

>>> src/sbm_back.sv
`timescale 1ns / 1ps
// Back end: command decoder, address tracking, byte store and result register.
// Depends on sbm_pkg (item_t, cfg_t, widths).
module sbm_back
#(
    parameter int STORE_BYTES = sbm_pkg::STORE_BYTES_DEFAULT
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  sbm_pkg::cfg_t   cfg,
    input  sbm_pkg::item_t  q_item,
    input  logic            q_valid,
    output logic            q_ready,
    output logic            clearing,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata     // [7:0] data_out
);

    localparam int IDX_W = $clog2(STORE_BYTES);
    localparam logic [sbm_pkg::ADDR_W:0] STORE_LIMIT = (sbm_pkg::ADDR_W + 1)'(STORE_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STORE_BYTES - 1);

    localparam logic [1:0] ACT_IDLE   = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_WRITE  = 2'd2;
    localparam logic [1:0] ACT_STATUS = 2'd3;

    localparam logic [7:0] OP_WRITE      = 8'h02;
    localparam logic [7:0] OP_READ       = 8'h03;
    localparam logic [7:0] OP_WRDI       = 8'h04;
    localparam logic [7:0] OP_RDSR       = 8'h05;
    localparam logic [7:0] OP_WREN       = 8'h06;
    localparam logic [7:0] OP_WRITE_HIGH = 8'h0A;
    localparam logic [7:0] OP_READ_HIGH  = 8'h0B;

    localparam logic [sbm_pkg::ADDR_W-1:0] HIGH_BASE = 24'h000100;

    logic [7:0]                 mem [STORE_BYTES];
    logic [7:0]                 mem_q_reg;

    logic [1:0]                 active_reg;
    logic [1:0]                 active_next;
    logic [sbm_pkg::ADDR_W-1:0] addr_reg;
    logic [sbm_pkg::ADDR_W-1:0] addr_next;
    logic [1:0]                 left_reg;
    logic [1:0]                 left_next;
    logic                       wen_reg;
    logic                       wen_next;

    logic                       clearing_reg;
    logic [IDX_W-1:0]           clr_cnt_reg;

    logic                       ob_valid_reg;
    logic                       ob_mem_reg;
    logic [7:0]                 ob_byte_reg;

    logic                       fire;
    logic                       in_range;
    logic [1:0]                 left_dec;
    logic [7:0]                 res_byte;
    logic                       res_mem;
    logic                       rd_en;
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_idx;
    logic [7:0]                 wr_data;
    logic                       acc_write;
    logic                       acc_high;
    logic                       acc_start;
    logic [7:0]                 d;

    assign clearing = clearing_reg;
    assign q_ready  = !clearing_reg && (!ob_valid_reg || m_tready);
    assign fire     = q_valid && q_ready;
    assign m_tvalid = ob_valid_reg;
    assign m_tdata  = ob_mem_reg ? mem_q_reg : ob_byte_reg;
    assign d        = q_item.data;

    assign in_range = ({1'b0, addr_reg} < {8'd0, cfg.size_in_use})
                   && ({1'b0, addr_reg} < STORE_LIMIT);
    assign left_dec = left_reg - 2'd1;

    always_comb
    begin
        active_next = active_reg;
        addr_next   = addr_reg;
        left_next   = left_reg;
        wen_next    = wen_reg;
        res_byte    = d;
        res_mem     = 1'b0;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        acc_start   = 1'b0;
        acc_write   = 1'b0;
        acc_high    = 1'b0;

        if (q_item.release_cs)
        begin
            if (active_reg == ACT_WRITE)
            begin
                wen_next = 1'b0;
            end
            active_next = ACT_IDLE;
            res_byte    = 8'd0;
        end
        else
        begin
            case (active_reg)
                ACT_READ, ACT_WRITE:
                begin
                    if (left_reg != 2'd0)
                    begin
                        left_next = left_dec;
                        case (left_dec)
                            2'd0:    addr_next[7:0]   = addr_reg[7:0] | d;
                            2'd1:    addr_next[15:8]  = addr_reg[15:8] | d;
                            2'd2:    addr_next[23:16] = addr_reg[23:16] | d;
                            default: addr_next        = addr_reg;
                        endcase
                    end
                    else if (in_range)
                    begin
                        if (active_reg == ACT_READ)
                        begin
                            rd_en   = 1'b1;
                            res_mem = 1'b1;
                        end
                        else
                        begin
                            wr_en = 1'b1;
                        end
                        addr_next = addr_reg + 24'd1;
                    end
                end
                ACT_STATUS:
                begin
                    res_byte = {6'd0, wen_reg, 1'b0};
                end
                default:
                begin
                    case (d)
                        OP_WRITE, OP_WRITE_HIGH:
                        begin
                            if (!wen_reg)
                            begin
                                res_byte = 8'd0;
                            end
                            else
                            begin
                                acc_start = 1'b1;
                                acc_write = 1'b1;
                                acc_high  = (d == OP_WRITE_HIGH);
                            end
                        end
                        OP_READ, OP_READ_HIGH:
                        begin
                            acc_start = 1'b1;
                            acc_high  = (d == OP_READ_HIGH);
                        end
                        OP_WRDI:
                        begin
                            wen_next = 1'b0;
                        end
                        OP_RDSR:
                        begin
                            active_next = ACT_STATUS;
                        end
                        OP_WREN:
                        begin
                            if (cfg.writable)
                            begin
                                wen_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            active_next = active_reg;
                        end
                    endcase
                    if (acc_start)
                    begin
                        addr_next   = (acc_high && cfg.address_bytes == 2'd1) ? HIGH_BASE : '0;
                        left_next   = cfg.address_bytes;
                        active_next = acc_write ? ACT_WRITE : ACT_READ;
                    end
                end
            endcase
        end
    end

    assign wr_idx  = clearing_reg ? clr_cnt_reg : addr_reg[IDX_W-1:0];
    assign wr_data = clearing_reg ? 8'd0 : d;

    always_ff @(posedge clk)
    begin
        if (clearing_reg || (fire && wr_en))
        begin
            mem[wr_idx] <= wr_data;
        end
        if (fire && rd_en)
        begin
            mem_q_reg <= mem[addr_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            ob_byte_reg <= res_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= ACT_IDLE;
            addr_reg     <= '0;
            left_reg     <= 2'd0;
            wen_reg      <= 1'b0;
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            ob_valid_reg <= 1'b0;
            ob_mem_reg   <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                if (clr_cnt_reg == LAST_IDX)
                begin
                    clearing_reg <= 1'b0;
                end
                else
                begin
                    clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
                end
            end
            if (fire)
            begin
                active_reg   <= active_next;
                addr_reg     <= addr_next;
                left_reg     <= left_next;
                wen_reg      <= wen_next;
                ob_valid_reg <= 1'b1;
                ob_mem_reg   <= res_mem;
            end
            else if (m_tready)
            begin
                ob_valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench for spi_backup_memory_slave: directed and random SPI byte requests with random
// flow control, checked against a behavioral model of the serial memory. Depends on sbm_pkg.
module tb;

    localparam int STORE_BYTES = sbm_pkg::STORE_BYTES_DEFAULT;
    localparam int SIZE_W      = sbm_pkg::SIZE_W;
    localparam int CYCLE_LIMIT = 1000000;

    localparam logic [7:0] CMD_WRITE    = 8'h02;
    localparam logic [7:0] CMD_READ     = 8'h03;
    localparam logic [7:0] CMD_WRDI     = 8'h04;
    localparam logic [7:0] CMD_RDSR     = 8'h05;
    localparam logic [7:0] CMD_WREN     = 8'h06;
    localparam logic [7:0] CMD_WRITE_HI = 8'h0A;
    localparam logic [7:0] CMD_READ_HI  = 8'h0B;
    localparam logic [23:0] HIGH_BASE   = 24'h000100;

    typedef enum int
    {
        REG_ADDR_BYTES  = 0,
        REG_SIZE_IN_USE = 1,
        REG_WRITABLE    = 2
    } reg_e;

    typedef enum logic [1:0]
    {
        MODE_IDLE,
        MODE_READ,
        MODE_WRITE,
        MODE_STATUS
    } mode_e;

    typedef logic [7:0] byte_q_t[$];

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = 4'h0;
    logic [31:0] pwdata   = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    // Model state of the memory part
    logic [1:0]        cfg_abytes;
    logic [SIZE_W-1:0] cfg_size;
    logic              cfg_writable;
    mode_e             mode;
    logic [23:0]       cur_addr;
    logic [1:0]        addr_left;
    logic              wen;
    logic [7:0]        mem [0:STORE_BYTES-1];

    logic [7:0] miso_expect[$];
    int         mismatches = 0;
    int         sent_reqs  = 0;
    int         cycles     = 0;
    int         gap_pct    = 0;
    int         stall_pct  = 0;
    int         hold_req   = 0;
    int         hold_left  = 0;

    spi_backup_memory_slave u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic flag_mismatch(string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic void start_access(mode_e kind, logic high);
        cur_addr  = (high && cfg_abytes == 2'd1) ? HIGH_BASE : 24'h0;
        addr_left = cfg_abytes;
        mode      = kind;
    endfunction

    // Byte returned to the master for one request; updates the model state
    function automatic logic [7:0] spi_exchange(logic rel, logic [7:0] d);
        logic [7:0] r;
        r = d;
        if (rel)
        begin
            if (mode == MODE_WRITE)
                wen = 1'b0;
            mode = MODE_IDLE;
            return 8'h00;
        end
        case (mode)
            MODE_READ, MODE_WRITE:
            begin
                if (addr_left != 2'd0)
                begin
                    addr_left = addr_left - 2'd1;
                    cur_addr  = cur_addr | (24'(d) << (addr_left * 8));
                end
                else if (cur_addr < 24'(cfg_size) && cur_addr < 24'(STORE_BYTES))
                begin
                    if (mode == MODE_READ)
                        r = mem[cur_addr];
                    else
                        mem[cur_addr] = d;
                    cur_addr = cur_addr + 24'd1;
                end
            end
            MODE_STATUS:
                r = {6'b0, wen, 1'b0};
            default:
            begin
                case (d)
                    CMD_WRITE, CMD_WRITE_HI:
                    begin
                        if (!wen)
                            r = 8'h00;
                        else
                            start_access(MODE_WRITE, d == CMD_WRITE_HI);
                    end
                    CMD_READ, CMD_READ_HI:
                        start_access(MODE_READ, d == CMD_READ_HI);
                    CMD_WRDI:
                        wen = 1'b0;
                    CMD_RDSR:
                        mode = MODE_STATUS;
                    CMD_WREN:
                        if (cfg_writable)
                            wen = 1'b1;
                    default:
                        ;
                endcase
            end
        endcase
        return r;
    endfunction

    // Receiver: random stalls plus an optional long hold
    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin : result_check
        logic [7:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (miso_expect.size() == 0)
                flag_mismatch($sformatf("unexpected data_out %02h", m_tdata));
            else
            begin
                want = miso_expect.pop_front();
                if (m_tdata !== want)
                    flag_mismatch($sformatf("data_out %02h, want %02h", m_tdata, want));
            end
        end
    end

    task automatic send_req(logic rel, logic [7:0] d);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= rel;
        do
            @(posedge clk);
        while (!s_tready);
        miso_expect.push_back(spi_exchange(rel, d));
        sent_reqs++;
    endtask

    task automatic frame(byte_q_t b);
        foreach (b[i])
            send_req(1'b0, b[i]);
        send_req(1'b1, 8'($urandom_range(0, 255)));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (miso_expect.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(reg_e idx, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(int'(idx) * 4);
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_ADDR_BYTES:  cfg_abytes   = v[1:0];
            REG_SIZE_IN_USE: cfg_size     = v[SIZE_W-1:0];
            default:         cfg_writable = v[0];
        endcase
    endtask

    task automatic configure(int ab, int sz, int wr);
        drain();
        apb_write(REG_ADDR_BYTES, 32'(ab));
        apb_write(REG_SIZE_IN_USE, 32'(sz));
        apb_write(REG_WRITABLE, 32'(wr));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [23:0] pick_address();
        int lim;
        int a;
        lim = (int'(cfg_size) < STORE_BYTES) ? int'(cfg_size) : STORE_BYTES;
        case ($urandom_range(0, 3))
            0: a = $urandom_range(0, 63);
            1:
            begin
                a = lim - int'($urandom_range(0, 6));
                if (a < 0)
                    a = 0;
            end
            2: a = $urandom_range(0, 65535);
            default: a = $urandom_range(0, 24'hFFFFFF);
        endcase
        return 24'(a);
    endfunction

    task automatic random_config();
        int ab;
        int sz;
        ab = $urandom_range(0, 9);
        ab = (ab == 0) ? 0 : (ab <= 3) ? 1 : (ab <= 6) ? 2 : 3;
        case ($urandom_range(0, 4))
            0: sz = STORE_BYTES;
            1: sz = 512;
            2: sz = 17'h1FFFF;
            3: sz = $urandom_range(0, 65536);
            default: sz = $urandom_range(1, 128);
        endcase
        configure(ab, sz, ($urandom_range(0, 4) != 0) ? 1 : 0);
    endtask

    task automatic random_sequence();
        byte_q_t q;
        int k;
        int n;
        logic [23:0] a;
        k = $urandom_range(0, 99);
        if (k < 60)
        begin
            if (k < 30)
                q = '{(($urandom_range(0, 2) == 0) ? CMD_READ_HI : CMD_READ)};
            else
            begin
                if ($urandom_range(0, 99) < 85)
                    frame('{CMD_WREN});
                q = '{(($urandom_range(0, 2) == 0) ? CMD_WRITE_HI : CMD_WRITE)};
            end
            a = pick_address();
            for (int i = int'(cfg_abytes) - 1; i >= 0; i--)
                q.push_back(a[i*8 +: 8]);
            n = $urandom_range(0, 8);
            repeat (n) q.push_back(8'($urandom_range(0, 255)));
            // broken transfer: release arrives early
            if ($urandom_range(0, 9) == 0)
                q = q[0:$urandom_range(0, q.size() - 1)];
            frame(q);
        end
        else if (k < 70)
            frame('{CMD_RDSR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))});
        else if (k < 75)
            frame('{CMD_WRDI});
        else if (k < 80)
            frame('{CMD_WREN});
        else
        begin
            n = $urandom_range(1, 6);
            repeat (n) send_req($urandom_range(0, 4) == 0, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_command_set();
        send_req(1'b1, 8'h5A);
        frame('{8'h00, 8'hFF});
        frame('{CMD_WRITE});
        frame('{CMD_WREN});
        frame('{CMD_RDSR, 8'hFF});
        frame('{CMD_WRITE_HI, 8'hFF, 8'hFF, 8'hA5, 8'h5A});
        frame('{CMD_READ_HI, 8'hFF, 8'hFF, 8'h00, 8'h00});
        frame('{CMD_WRDI});
    endtask

    task automatic test_address_modes();
        configure(1, 512, 0);
        frame('{CMD_WREN});
        frame('{CMD_WRITE});
        configure(1, 512, 1);
        frame('{CMD_WREN});
        frame('{CMD_WRITE_HI, 8'hFF, 8'h11, 8'h22});
        frame('{CMD_READ_HI, 8'hFF, 8'h00});
        configure(3, 17'h1FFFF, 1);
        frame('{CMD_READ, 8'h01, 8'h00, 8'h00, 8'h00});
        configure(0, 0, 1);
        frame('{CMD_READ, 8'h00});
        configure(0, STORE_BYTES, 1);
        frame('{CMD_READ, 8'h00, 8'h00});
    endtask

    task automatic test_random_traffic(int sender_idle, int receiver_idle, int count);
        int target;
        int stop;
        gap_pct   = sender_idle;
        stall_pct = receiver_idle;
        target    = sent_reqs + count;
        while (sent_reqs < target)
        begin
            random_config();
            stop = sent_reqs + 45;
            while (sent_reqs < stop && sent_reqs < target)
                random_sequence();
        end
    endtask

    task automatic test_backpressure();
        gap_pct   = 0;
        stall_pct = 0;
        configure(2, STORE_BYTES, 1);
        hold_req = 200;
        repeat (4) frame('{CMD_READ, 8'h00, 8'($urandom_range(0, 63)),
                           8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                           8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    endtask

    initial
    begin
        for (int i = 0; i < STORE_BYTES; i++)
            mem[i] = 8'h00;
        cfg_abytes   = 2'd2;
        cfg_size     = SIZE_W'(STORE_BYTES);
        cfg_writable = 1'b1;
        mode         = MODE_IDLE;
        cur_addr     = 24'h0;
        addr_left    = 2'd0;
        wen          = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct   = 34;
        stall_pct = 64;
        test_command_set();
        test_address_modes();
        test_random_traffic(34, 64, 90);
        test_random_traffic(64, 34, 90);
        test_random_traffic(0, 0, 90);
        test_backpressure();

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
